/* rtl/thc_pkg.sv */
package thc_pkg;

  localparam int Q = 30;
  localparam int LOG_TABLE_BITS_DEF = 8;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int LN_LAT = 5;
  localparam int DIV_BITS = 16;

  localparam logic [Q-1:0] LN2_Q30 = 30'd744261118;

  localparam logic signed [33:0] COEF_A = -34'sd2876814999;
  localparam logic signed [34:0] COEF_B = 35'sd7682314132;
  localparam logic signed [24:0] COEF_C = -25'sd11406426;

  localparam logic [51:0] KELVIN_NUM = 52'd100 << 44;
  localparam logic signed [17:0] KELVIN_OFFSET = 18'sd27315;
  localparam logic signed [15:0] TEMP_LOW = -16'sd27315;
  localparam logic signed [15:0] TEMP_HIGH = 16'sd32767;
  localparam logic signed [21:0] TEMP_REF = 22'sd2300;

  localparam logic [16:0] HUM_GAIN = 17'd116760;
  localparam logic signed [37:0] HUM_OFFSET = 38'sd5507252224;
  localparam logic signed [21:0] HUM_ROUND = 22'sd10;
  localparam logic signed [21:0] HUM_BIAS_SCALED = 22'sd163840;
  localparam logic signed [21:0] HUM_TOP_SCALED = 22'sd819199;
  localparam logic [19:0] RECIP_20 = 20'd838861;
  localparam logic signed [15:0] HUM_BIAS = 16'sd8192;

  typedef enum logic [0:0] {
    REG_SERIES = 1'b0,
    REG_SUPPLY = 1'b1
  } cfg_reg_t;

  // shift-subtract quotient, only for building constant tables
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + k/2^bits) in q30 via 2*atanh series
  function automatic logic [Q:0] ln_entry(int unsigned k, int unsigned bits);
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] p;
    logic [63:0] s;
    y = udiv64(64'(k) << Q, (64'd1 << (bits + 1)) + 64'(k));
    y2 = (y * y) >> Q;
    p = y;
    s = '0;
    for (int n = 0; n < 40; n++) begin
      if (p != '0) begin
        s = s + udiv64(p, 64'(2 * n + 1));
        p = (p * y2) >> Q;
      end
    end
    return (Q + 1)'(s << 1);
  endfunction

endpackage

/* rtl/thc_ln.sv */
module thc_ln #(
  parameter int NW = 39,
  parameter int LOG_TABLE_BITS = thc_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic clk,
  input  logic [NW-1:0] n,
  output logic [$clog2(NW)+thc_pkg::Q-1:0] ln
);
  import thc_pkg::*;

  localparam int EW = $clog2(NW);
  localparam int OW = EW + Q;
  localparam int SH = Q - LOG_TABLE_BITS;
  localparam int TN = 2 ** LOG_TABLE_BITS;
  localparam int PW = 2 * SH;

  logic [Q:0] tab [TN+1];

  for (genvar k = 0; k <= TN; k++) begin : g_tab
    localparam logic [Q:0] ENTRY = ln_entry(k, LOG_TABLE_BITS);
    assign tab[k] = ENTRY;
  end

  logic [EW-1:0] e_c;
  logic [NW-1:0] s1_n;
  logic [EW-1:0] s1_e;
  logic [NW+Q-1:0] norm;
  logic [LOG_TABLE_BITS-1:0] s2_idx;
  logic [SH-1:0] s2_rem;
  logic [EW-1:0] s2_e;
  logic [LOG_TABLE_BITS:0] idx0;
  logic [LOG_TABLE_BITS:0] idx1;
  logic [SH-1:0] s3_diff;
  logic [SH-1:0] s3_rem;
  logic [OW-1:0] s3_base;
  logic [PW-1:0] prod;
  logic [SH-1:0] s4_frac;
  logic [OW-1:0] s4_base;

  // leading one position
  always_comb begin
    e_c = '0;
    for (int i = 0; i < NW; i++) begin
      if (n[i]) begin
        e_c = EW'(i);
      end
    end
  end

  assign norm = {s1_n, Q'(0)} >> s1_e;
  assign idx0 = {1'b0, s2_idx};
  assign idx1 = idx0 + 1'b1;
  assign prod = PW'(s3_diff) * PW'(s3_rem);

  always_ff @(posedge clk) begin
    s1_n <= n;
    s1_e <= e_c;
    s2_idx <= norm[Q-1:SH];
    s2_rem <= norm[SH-1:0];
    s2_e <= s1_e;
    s3_diff <= SH'(tab[idx1] - tab[idx0]);
    s3_rem <= s2_rem;
    s3_base <= OW'(s2_e) * OW'(LN2_Q30) + OW'(tab[idx0]);
    s4_frac <= SH'(prod >> SH);
    s4_base <= s3_base;
    ln <= s4_base + OW'(s4_frac);
  end

endmodule

/* rtl/thermistor_humidity_conversion.sv */
// thermistor and humidity sensor conversion, fully pipelined
// request channel: start with thermistor_voltage and humidity_voltage; busy is
// never raised, so a new request is taken on every clock cycle
// result channel: done is high for one cycle with temperature_centi,
// humidity_centi and reading_invalid; results come out in request order
// throughput: one request per cycle; the ln tables, three multiplier stages
// and a 16-stage restoring divider for the kelvin reciprocal are all pipelined
// configuration: cfg_we writes cfg_data into the register picked by cfg_addr
// (0 series resistance in ohms, 1 supply level); write only while no request
// is in flight
// reset: rst clears all valid bits and loads 36000 ohms and a 5 V supply
// the receiver cannot stall: done is a strobe and must be taken when shown
module thermistor_humidity_conversion #(
  parameter int LOG_TABLE_BITS = thc_pkg::LOG_TABLE_BITS_DEF,
  parameter int FRACTION_BITS = thc_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [18:0] thermistor_voltage,
  input  logic [18:0] humidity_voltage,
  output logic done,
  output logic signed [15:0] temperature_centi,
  output logic signed [15:0] humidity_centi,
  output logic reading_invalid,
  input  logic cfg_we,
  input  logic [0:0] cfg_addr,
  input  logic [19:0] cfg_data
);
  import thc_pkg::*;

  localparam int N1W = 39;
  localparam int N2W = 19;
  localparam int LN1W = $clog2(N1W) + Q;
  localparam int LN2W = $clog2(N2W) + Q;
  localparam int LDW = LN1W + 1;
  localparam int LW = FRACTION_BITS + 6;
  localparam int L2W = FRACTION_BITS + 11;
  localparam int L3W = FRACTION_BITS + 16;
  localparam int DW = 42;
  localparam int PQ = 2 * LW;
  localparam int PR = L2W + LW;
  localparam int PB = 35 + LW;
  localparam int PC = 25 + L3W;
  localparam int DDW = DW - 1;
  localparam int RW = 58;
  localparam int SP = LN_LAT;
  localparam int SU = SP + 5;
  localparam int SV = SU + DIV_BITS + 1;
  localparam int SW = SV + 1;
  localparam int NS = SW + 1;
  localparam logic signed [LDW-1:0] HALF = LDW'(1) << (Q - FRACTION_BITS - 1);

  typedef struct packed {
    logic valid;
    logic inv;
    logic signed [21:0] hy;
  } side_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [DIV_BITS-1:0] q;
    logic [DDW-1:0] d;
    logic dpos;
    logic sat;
  } div_t;

  logic [19:0] series_res;
  logic [18:0] supply_lvl;

  logic a_valid;
  logic a_inv;
  logic [N1W-1:0] a_n1;
  logic [N2W-1:0] a_n2;
  logic [35:0] a_hp;
  logic signed [37:0] hx;
  side_t sd_in;
  side_t sd [NS];

  logic [LN1W-1:0] ln1;
  logic [LN2W-1:0] ln2;
  logic signed [LDW-1:0] l30;
  logic signed [LW-1:0] p_l;
  logic signed [PQ-1:0] sq;
  logic signed [L2W-1:0] q_l2;
  logic signed [LW-1:0] q_l;
  logic signed [PR-1:0] cube;
  logic signed [PB-1:0] bprod;
  logic signed [L3W-1:0] r_l3;
  logic signed [DW-1:0] r_bl;
  logic signed [PC-1:0] cprod;
  logic signed [DW-1:0] s_cl;
  logic signed [DW-1:0] s_bl;
  logic signed [DW-1:0] t_d;
  logic [DDW-1:0] u_d;
  logic [RW-1:0] u_num;
  div_t dv [DIV_BITS+1];
  logic signed [17:0] kc_off;
  logic signed [15:0] v_temp;
  logic signed [21:0] y;
  logic signed [21:0] yo;
  logic [19:0] w_y;
  logic signed [15:0] w_temp;
  logic [39:0] hprod;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_res <= 20'd36000;
      supply_lvl <= 19'd327680;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SERIES: series_res <= cfg_data;
        REG_SUPPLY: supply_lvl <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  // stage a: divider terms and humidity product
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start;
    end
    a_inv <= (thermistor_voltage == '0) || (thermistor_voltage >= supply_lvl)
             || (series_res == '0);
    a_n1 <= N1W'(thermistor_voltage) * N1W'(series_res);
    a_n2 <= supply_lvl - thermistor_voltage;
    a_hp <= 36'(humidity_voltage) * 36'(HUM_GAIN);
  end

  assign hx = $signed({2'b00, a_hp}) - HUM_OFFSET;
  assign sd_in = '{valid: a_valid, inv: a_inv, hy: 22'(hx >>> 16) + HUM_ROUND};

  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0] <= '0;
    end else begin
      sd[0] <= sd_in;
    end
  end

  for (genvar i = 1; i < NS; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i] <= '0;
      end else begin
        sd[i] <= sd[i-1];
      end
    end
  end

  thc_ln #(.NW(N1W), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_ln_num (
    .clk(clk),
    .n(a_n1),
    .ln(ln1)
  );

  thc_ln #(.NW(N2W), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_ln_den (
    .clk(clk),
    .n(a_n2),
    .ln(ln2)
  );

  // ln r and steinhart-hart polynomial
  assign l30 = $signed({1'b0, ln1}) - $signed({2'b00, ln2}) + HALF;
  assign sq = PQ'(p_l) * PQ'(p_l);
  assign cube = PR'(q_l2) * PR'(q_l);
  assign bprod = PB'(COEF_B) * PB'(q_l);
  assign cprod = PC'(COEF_C) * PC'(r_l3);

  always_ff @(posedge clk) begin
    p_l <= LW'(l30 >>> (Q - FRACTION_BITS));
    q_l2 <= L2W'(sq >>> FRACTION_BITS);
    q_l <= p_l;
    r_l3 <= L3W'(cube >>> FRACTION_BITS);
    r_bl <= DW'(bprod >>> FRACTION_BITS);
    s_cl <= DW'(cprod >>> FRACTION_BITS);
    s_bl <= r_bl;
    t_d <= DW'(COEF_A) + s_bl + s_cl;
  end

  // reciprocal: 16 quotient bits, one per stage
  assign u_d = t_d[DDW-1:0];
  assign u_num = RW'(KELVIN_NUM) + RW'(u_d >> 1);

  always_ff @(posedge clk) begin
    dv[0].rem <= u_num;
    dv[0].q <= '0;
    dv[0].d <= u_d;
    dv[0].dpos <= (t_d > 0);
    dv[0].sat <= (u_num >= (RW'(u_d) << DIV_BITS));
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - k;
    div_t dv_next;
    always_comb begin
      dv_next = dv[k-1];
      if (dv[k-1].rem >= (RW'(dv[k-1].d) << B)) begin
        dv_next.rem = dv[k-1].rem - (RW'(dv[k-1].d) << B);
        dv_next.q[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      dv[k] <= dv_next;
    end
  end

  assign kc_off = $signed({2'b00, dv[DIV_BITS].q}) - KELVIN_OFFSET;

  always_ff @(posedge clk) begin
    if (sd[SV-1].inv) begin
      v_temp <= '0;
    end else if (!dv[DIV_BITS].dpos) begin
      v_temp <= TEMP_LOW;
    end else if (dv[DIV_BITS].sat || kc_off > 18'(TEMP_HIGH)) begin
      v_temp <= TEMP_HIGH;
    end else begin
      v_temp <= 16'(kc_off);
    end
  end

  // humidity with temperature correction, clamped and offset to stay positive
  assign y = sd[SV].hy + (sd[SV].inv ? 22'sd0 : (22'(v_temp) - TEMP_REF));
  assign yo = y + HUM_BIAS_SCALED;

  always_ff @(posedge clk) begin
    w_temp <= v_temp;
    if (yo < 0) begin
      w_y <= '0;
    end else if (yo > HUM_TOP_SCALED) begin
      w_y <= 20'(HUM_TOP_SCALED);
    end else begin
      w_y <= 20'(yo);
    end
  end

  assign hprod = 40'(w_y) * 40'(RECIP_20);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sd[SW].valid;
    end
    temperature_centi <= w_temp;
    humidity_centi <= $signed(16'(hprod >> 24)) - HUM_BIAS;
    reading_invalid <= sd[SW].inv;
  end

endmodule
